@@ hw/rtl/ghsb_pkg.sv @@
// ghsb_pkg: shared constants, types and operation codes of the grey histogram block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ghsb_pkg;

    localparam int COUNT_WIDTH  = 21;
    localparam int BIN_TOTAL    = 256;
    localparam int BIN_AW       = $clog2(BIN_TOTAL);
    localparam int BAR_SCALE    = 240;
    localparam int SCALE_W      = $clog2(BAR_SCALE);
    localparam int DIV_WIDTH    = COUNT_WIDTH - SCALE_W + 1;
    localparam int HEIGHT_WIDTH = 9;
    localparam int HEIGHT_LIMIT = 2 * BAR_SCALE - 1;
    localparam int DSH_WIDTH    = DIV_WIDTH + HEIGHT_WIDTH - 1;
    localparam int STEP_W       = $clog2(HEIGHT_WIDTH);
    localparam int IN_DATA_W    = 24;
    localparam int IN_USER_W    = 2;
    localparam int OUT_DATA_W   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [DIV_WIDTH-1:0]   t_divisor;
    typedef logic [HEIGHT_WIDTH-1:0] t_height;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } t_div_state;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [BIN_AW-1:0] pixel;
        logic              selected;
        logic [BIN_AW-1:0] bin_index;
    } t_item;

    typedef struct packed {
        logic     valid;
        t_count   count;
        t_divisor divisor;
    } t_bin_rd;

endpackage

`default_nettype wire

@@ hw/rtl/ghsb_ram.sv @@
// ghsb_ram: generic single-clock ram, one write port, one registered read port
// no dependencies; read during write of the same address returns the old word
`timescale 1ns / 1ps
`default_nettype none

module ghsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/ghsb_bins.sv @@
// ghsb_bins: bin store with read-modify-write pipeline, valid bits, running maximum
// depends on ghsb_pkg and ghsb_ram
`timescale 1ns / 1ps
`default_nettype none

module ghsb_bins (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ghsb_pkg::t_item  i_item,
    input  wire logic             i_sel_only,
    output ghsb_pkg::t_bin_rd     o_rd
);
    import ghsb_pkg::*;

    localparam logic [SCALE_W-1:0] SCALE_LAST = SCALE_W'(BAR_SCALE - 1);

    t_op               s0_op;
    logic [BIN_AW-1:0] s0_addr;
    t_count            ram_rdata;
    t_count            s1_old;
    t_count            s1_new;
    logic              s1_we;
    logic              s1_fwd_hit;

    t_op                r_s1_op;
    logic [BIN_AW-1:0]  r_s1_addr;
    logic [BIN_TOTAL-1:0] r_vld;
    logic               r_fwd_valid;
    logic [BIN_AW-1:0]  r_fwd_addr;
    t_count             r_fwd_data;
    t_count             r_largest;
    t_divisor           r_div_q;
    logic [SCALE_W-1:0] r_div_r;

    // stage 0: decode transaction, issue ram read
    always_comb begin
        s0_op   = OP_NONE;
        s0_addr = i_item.bin_index;
        if (i_item.valid) begin
            unique case (i_item.op)
                OP_ADD: begin
                    s0_addr = i_item.pixel;
                    if (!i_sel_only || i_item.selected) begin
                        s0_op = OP_ADD;
                    end
                end
                OP_READ:  s0_op = OP_READ;
                OP_CLEAR: s0_op = OP_CLEAR;
                OP_NONE:  s0_op = OP_NONE;
            endcase
        end
    end

    ghsb_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(BIN_TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_s1_addr),
        .i_wdata (s1_new),
        .i_raddr (s0_addr),
        .o_rdata (ram_rdata)
    );

    // stage 1: forward last write, modify, write back
    always_comb begin
        s1_fwd_hit = r_fwd_valid && (r_fwd_addr == r_s1_addr);
        if (s1_fwd_hit) begin
            s1_old = r_fwd_data;
        end else if (r_vld[r_s1_addr]) begin
            s1_old = ram_rdata;
        end else begin
            s1_old = '0;
        end
        s1_new = (s1_old == COUNT_MAX) ? s1_old : s1_old + t_count'(1);
        s1_we  = (r_s1_op == OP_ADD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op     <= OP_NONE;
            r_vld       <= '0;
            r_fwd_valid <= 1'b0;
            r_largest   <= '0;
            r_div_q     <= '0;
            r_div_r     <= '0;
        end else begin
            r_s1_op     <= s0_op;
            r_fwd_valid <= s1_we;
            if (r_s1_op == OP_CLEAR) begin
                r_vld     <= '0;
                r_largest <= '0;
                r_div_q   <= '0;
                r_div_r   <= '0;
            end else if (s1_we) begin
                r_vld[r_s1_addr] <= 1'b1;
                // maximum grows by one at a time, so track it divided by the scale
                if (s1_new > r_largest) begin
                    r_largest <= s1_new;
                    if (r_div_r == SCALE_LAST) begin
                        r_div_r <= '0;
                        r_div_q <= r_div_q + t_divisor'(1);
                    end else begin
                        r_div_r <= r_div_r + SCALE_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= s0_addr;
        r_fwd_addr <= r_s1_addr;
        r_fwd_data <= s1_new;
    end

    assign o_rd.valid   = (r_s1_op == OP_READ);
    assign o_rd.count   = s1_old;
    assign o_rd.divisor = (r_div_q == '0) ? t_divisor'(1) : r_div_q;

endmodule

`default_nettype wire

@@ hw/rtl/ghsb_div.sv @@
// ghsb_div: bit-serial bar height divider and result output register
// depends on ghsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ghsb_div (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ghsb_pkg::t_bin_rd    i_rd,
    input  wire logic                 i_out_ready,
    output logic                      o_busy,
    output logic                      o_valid,
    output ghsb_pkg::t_count          o_count,
    output ghsb_pkg::t_height         o_height
);
    import ghsb_pkg::*;

    t_div_state r_state;
    t_div_state n_state;

    t_count                r_rem;
    t_count                r_cnt;
    logic [DSH_WIDTH-1:0]  r_dsh;
    t_height               r_quo;
    logic [STEP_W-1:0]     r_step;
    logic                  r_out_valid;
    t_count                r_out_count;
    t_height               r_out_height;

    logic fits;
    logic out_free;
    logic load_out;

    always_comb begin
        fits     = DSH_WIDTH'(r_rem) >= r_dsh;
        out_free = !r_out_valid || i_out_ready;
        load_out = 1'b0;
        n_state  = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (i_rd.valid) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_step == '0) begin
                    n_state = DIV_HOLD;
                end
            end
            DIV_HOLD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DIV_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // restoring division, one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_rd.valid) begin
            r_rem  <= i_rd.count;
            r_cnt  <= i_rd.count;
            r_dsh  <= DSH_WIDTH'(i_rd.divisor) << (HEIGHT_WIDTH - 1);
            r_quo  <= '0;
            r_step <= STEP_W'(HEIGHT_WIDTH - 1);
        end else if (r_state == DIV_RUN) begin
            if (fits) begin
                r_rem <= r_rem - r_dsh[COUNT_WIDTH-1:0];
            end
            r_dsh  <= r_dsh >> 1;
            r_quo  <= {r_quo[HEIGHT_WIDTH-2:0], fits};
            r_step <= r_step - STEP_W'(1);
        end
        if (load_out) begin
            r_out_count  <= r_cnt;
            r_out_height <= r_quo;
        end
    end

    assign o_busy   = (r_state != DIV_IDLE);
    assign o_valid  = r_out_valid;
    assign o_count  = r_out_count;
    assign o_height = r_out_height;

endmodule

`default_nettype wire

@@ hw/rtl/grey_histogram_scaled_bars.sv @@
// grey_histogram_scaled_bars: top level of the 256-bin grey histogram with bar heights
// depends on ghsb_pkg, ghsb_bins, ghsb_div
//
// usage:
//   s_axis carries one operation per transaction; tuser holds the operation code
//   (add pixel, read bin, clear). tdata holds pixel_value, selected and bin_index.
//   m_axis returns one result per read: bin_count and bar_height in tdata.
//   the cfg channel writes selected_only; o_cfg_ready is always high.
//   add and clear can be issued back to back; an add
//   right behind an add to the same bin is forwarded inside the pipeline.
//   a read holds s_axis_tready low after its transaction until its result is
//   loaded: the bin store read, the bit-serial divider (nine quotient bits,
//   one quotient bit per cycle) and the load of the output register.
//   if the receiver stalls, the result waits in the output register while adds
//   and clears keep flowing; a second read waits in the divider until the
//   output register is free.
//   reset clears all bins at once through per-bin valid bits, the maximum,
//   selected_only and the output register; the block is ready the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module grey_histogram_scaled_bars (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pixel_value [7:0], selected [8], bin_index [16:9], zero fill
    input  wire logic [ghsb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation [1:0]
    input  wire logic [ghsb_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // bin_count [20:0], bar_height [29:21], zero fill
    output logic      [ghsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_cfg_data
);
    import ghsb_pkg::*;

    logic    r_sel_only;
    t_item   item;
    t_bin_rd bin_rd;
    logic    div_busy;
    t_count  out_count;
    t_height out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_only <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sel_only <= i_cfg_data;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !div_busy && !bin_rd.valid;

    assign item.valid     = s_axis_tvalid && s_axis_tready;
    assign item.op        = t_op'(s_axis_tuser);
    assign item.pixel     = s_axis_tdata[BIN_AW-1:0];
    assign item.selected  = s_axis_tdata[BIN_AW];
    assign item.bin_index = s_axis_tdata[2*BIN_AW:BIN_AW+1];

    ghsb_bins u_bins (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_sel_only (r_sel_only),
        .o_rd       (bin_rd)
    );

    ghsb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (bin_rd),
        .i_out_ready (m_axis_tready),
        .o_busy      (div_busy),
        .o_valid     (m_axis_tvalid),
        .o_count     (out_count),
        .o_height    (out_height)
    );

    assign m_axis_tdata = OUT_DATA_W'({out_height, out_count});

endmodule

`default_nettype wire

@@ hw/rtl/ghsb_checker.sv @@
// ghsb_checker: port-level assertions for grey_histogram_scaled_bars, with bind
// depends on ghsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module ghsb_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic [ghsb_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [ghsb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import ghsb_pkg::*;

    logic [HEIGHT_WIDTH-1:0] height;
    logic                    read_taken;

    assign height     = m_axis_tdata[COUNT_WIDTH+HEIGHT_WIDTH-1:COUNT_WIDTH];
    assign read_taken = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_READ);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        read_taken |=> !s_axis_tready)
        else $error("input ready right after a read transaction");

    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> height <= HEIGHT_WIDTH'(HEIGHT_LIMIT))
        else $error("bar height out of range");

endmodule

bind grey_histogram_scaled_bars ghsb_checker u_ghsb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/histogram_bar_checker.sv @@
// histogram_bar_checker: watches the stream and config channels of the grey histogram block,
// predicts every bar reading from its own copy of the bins and compares the results
// depends on ghsb_pkg
`timescale 1ns / 1ps

module histogram_bar_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    input  wire logic                            s_axis_tready,
    // pixel_value [7:0], selected [8], bin_index [16:9], zero fill
    input  wire logic [ghsb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation [1:0]
    input  wire logic [ghsb_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  wire logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // bin_count [20:0], bar_height [29:21], zero fill
    input  wire logic [ghsb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic                            i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_bars_checked,
    output int                                   o_pixels_counted,
    output int                                   o_clears_seen
);

    import ghsb_pkg::*;

    typedef struct packed {
        t_count  count;
        t_height height;
    } t_bar_reading;

    t_count       bin_tally [BIN_TOTAL];
    t_count       peak_count;
    logic         count_selected_only;
    t_bar_reading pending_bars [$];
    int           fail_total;
    int           bars_total;
    int           pixels_total;
    int           clears_total;

    function automatic t_height scaled_height(input t_count count, input t_count peak);
        t_count divisor;
        divisor = peak / BAR_SCALE;
        if (divisor == '0) begin
            divisor = 1;
        end
        return t_height'(count / divisor);
    endfunction

    always @(posedge i_clk) begin
        t_op          op;
        logic [7:0]   pix;
        logic         sel;
        logic [7:0]   idx;
        t_bar_reading want;
        t_bar_reading got;
        if (!i_rst_n) begin
            for (int b = 0; b < BIN_TOTAL; b++) begin
                bin_tally[b] = '0;
            end
            peak_count = '0;
            count_selected_only = 1'b0;
            pending_bars.delete();
            fail_total = 0;
            bars_total = 0;
            pixels_total = 0;
            clears_total = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                count_selected_only = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                op  = t_op'(s_axis_tuser);
                pix = s_axis_tdata[7:0];
                sel = s_axis_tdata[8];
                idx = s_axis_tdata[16:9];
                case (op)
                    OP_ADD: begin
                        if (!(count_selected_only && !sel)) begin
                            if (bin_tally[pix] != COUNT_MAX) begin
                                bin_tally[pix] = bin_tally[pix] + 1'b1;
                            end
                            if (bin_tally[pix] > peak_count) begin
                                peak_count = bin_tally[pix];
                            end
                            pixels_total++;
                        end
                    end
                    OP_READ: begin
                        want.count  = bin_tally[idx];
                        want.height = scaled_height(bin_tally[idx], peak_count);
                        pending_bars.push_back(want);
                    end
                    OP_CLEAR: begin
                        for (int b = 0; b < BIN_TOTAL; b++) begin
                            bin_tally[b] = '0;
                        end
                        peak_count = '0;
                        clears_total++;
                    end
                    default: begin
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.count  = m_axis_tdata[COUNT_WIDTH-1:0];
                got.height = m_axis_tdata[COUNT_WIDTH +: HEIGHT_WIDTH];
                if (pending_bars.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, got count %0d height %0d",
                             $time, got.count, got.height);
                end else begin
                    want = pending_bars.pop_front();
                    bars_total++;
                    if (got.count != want.count) begin
                        fail_total++;
                        $display("%0t: bin count mismatch, expected %0d, got %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.height != want.height) begin
                        fail_total++;
                        $display("%0t: bar height mismatch, expected %0d, got %0d",
                                 $time, want.height, got.height);
                    end
                end
            end
        end
        o_fail_count     <= fail_total;
        o_pending        <= pending_bars.size();
        o_bars_checked   <= bars_total;
        o_pixels_counted <= pixels_total;
        o_clears_seen    <= clears_total;
    end

endmodule

@@ sim/grey_histogram_scaled_bars_tb.sv @@
// grey_histogram_scaled_bars_tb: drives pixel adds, bar reads and clears into the histogram
// block under both selected_only settings, with bursty input and a stalling receiver
// depends on ghsb_pkg, grey_histogram_scaled_bars, histogram_bar_checker
`timescale 1ns / 1ps

module grey_histogram_scaled_bars_tb;

    import ghsb_pkg::*;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_STREAKS
    } t_rx_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_data;

    int fail_count;
    int pending_reads;
    int bars_checked;
    int pixels_counted;
    int clears_seen;

    logic     feed_on;
    int       burst_left;
    logic     sel_only_now;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_hold = 0;
    logic     rx_level = 1'b0;

    grey_histogram_scaled_bars i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    histogram_bar_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .s_axis_tuser     (s_axis_tuser),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_reads),
        .o_bars_checked   (bars_checked),
        .o_pixels_counted (pixels_counted),
        .o_clears_seen    (clears_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver stall pattern, mode picked at random among open, coin, sparse and streaks
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: begin
                if (rx_hold <= 0) begin
                    rx_level = !rx_level;
                    rx_hold  = $urandom_range(1, 24);
                end
                rx_hold--;
                m_axis_tready <= rx_level;
            end
        endcase
    end

    task automatic push_item(input t_op op, input logic [7:0] pix, input logic sel,
                             input logic [7:0] idx);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, idx, sel, pix};
        feed_on = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                feed_on = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // stop feeding, wait for every bar reading and let the pipeline empty
    task automatic drain();
        int waited;
        if (feed_on) begin
            s_axis_tvalid <= 1'b0;
            feed_on = 1'b0;
        end
        waited = 0;
        @(posedge i_clk);
        while (pending_reads != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_selected_only(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sel_only_now = value;
    endtask

    task automatic random_phase(input int target, input logic [7:0] hot_hint, input logic use_hint);
        int         done;
        int         pick;
        t_op        op;
        logic [7:0] hot;
        logic [7:0] pix;
        logic [7:0] idx;
        logic       sel;
        done = 0;
        hot  = use_hint ? hot_hint : 8'($urandom_range(0, 252));
        while (done < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                op = OP_ADD;
            end else if (pick < 92) begin
                op = OP_READ;
            end else if (pick < 93) begin
                op = OP_CLEAR;
            end else begin
                op = OP_NONE;
            end
            pix = ($urandom_range(0, 9) < 6) ? hot + 8'($urandom_range(0, 3)) : 8'($urandom);
            idx = ($urandom_range(0, 1) == 1) ? hot + 8'($urandom_range(0, 3)) : 8'($urandom);
            sel = 1'($urandom_range(0, 1));
            push_item(op, pix, sel, idx);
            if (op != OP_NONE && !(op == OP_ADD && sel_only_now && !sel)) begin
                done++;
            end
        end
    endtask

    initial begin
        logic [7:0] deep_bin;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_NONE;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        i_rst_n       <= 1'b0;
        feed_on      = 1'b0;
        burst_left   = 1;
        sel_only_now = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_selected_only(1'b0);

        // empty store, extreme bins, back to back adds, unused code, clear
        push_item(OP_READ, 8'hFF, 1'b1, 8'd0);
        push_item(OP_READ, 8'h00, 1'b0, 8'd255);
        push_item(OP_ADD, 8'd0, 1'b0, 8'hFF);
        push_item(OP_ADD, 8'd255, 1'b0, 8'h00);
        push_item(OP_ADD, 8'd255, 1'b1, 8'hAA);
        push_item(OP_ADD, 8'd255, 1'b0, 8'h55);
        push_item(OP_NONE, 8'd128, 1'b1, 8'd128);
        push_item(OP_READ, 8'd0, 1'b0, 8'd0);
        push_item(OP_READ, 8'd0, 1'b0, 8'd255);
        push_item(OP_READ, 8'd255, 1'b1, 8'd128);
        push_item(OP_CLEAR, 8'hFF, 1'b1, 8'hFF);
        push_item(OP_READ, 8'd0, 1'b0, 8'd255);
        push_item(OP_ADD, 8'd7, 1'b1, 8'd0);
        push_item(OP_READ, 8'd0, 1'b0, 8'd7);

        // tallest bar: one bin at 479, then one more to halve the scale
        for (int k = 0; k < 479; k++) begin
            push_item(OP_ADD, 8'd200, 1'($urandom_range(0, 1)), 8'($urandom));
        end
        push_item(OP_ADD, 8'd7, 1'b0, 8'd0);
        push_item(OP_READ, 8'd0, 1'b0, 8'd200);
        push_item(OP_READ, 8'd0, 1'b0, 8'd7);
        push_item(OP_ADD, 8'd200, 1'b0, 8'd0);
        push_item(OP_READ, 8'd0, 1'b0, 8'd200);
        push_item(OP_READ, 8'd0, 1'b0, 8'd7);
        push_item(OP_READ, 8'd0, 1'b0, 8'd201);
        drain();

        write_selected_only(1'b1);
        push_item(OP_ADD, 8'd9, 1'b0, 8'd0);
        push_item(OP_ADD, 8'd9, 1'b1, 8'd0);
        push_item(OP_READ, 8'd9, 1'b0, 8'd9);
        push_item(OP_READ, 8'd0, 1'b1, 8'd200);
        random_phase(120, 8'd0, 1'b0);
        drain();

        write_selected_only(1'b0);
        random_phase(100, 8'd0, 1'b0);

        // one bin pulled ahead of the rest while reads sample it
        deep_bin = 8'($urandom);
        for (int k = 0; k < 60; k++) begin
            push_item(OP_ADD, deep_bin, 1'($urandom_range(0, 1)), 8'($urandom));
            if (k % 30 == 29) begin
                push_item(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), deep_bin);
                push_item(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), 8'($urandom));
            end
        end
        push_item(OP_READ, 8'd0, 1'b0, deep_bin);
        push_item(OP_READ, 8'd0, 1'b0, deep_bin ^ 8'd1);
        drain();

        write_selected_only(1'b1);
        random_phase(30, (deep_bin > 8'd252) ? 8'd252 : deep_bin, 1'b1);
        drain();

        $display("run covered %0d counted pixels, %0d bar reads and %0d clears",
                 pixels_counted, bars_checked, clears_seen);
        $display("selected_only set to 0 and 1, bars read at full scale and past a scale step");
        if (pending_reads != 0) begin
            $display("%0d bar readings never returned", pending_reads);
        end
        if (fail_count == 0 && pending_reads == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ghsb_pkg.sv
hw/rtl/ghsb_ram.sv
hw/rtl/ghsb_bins.sv
hw/rtl/ghsb_div.sv
hw/rtl/grey_histogram_scaled_bars.sv
hw/rtl/ghsb_checker.sv
sim/histogram_bar_checker.sv
sim/grey_histogram_scaled_bars_tb.sv
